FILE: rtl/pol_pkg.sv
package pol_pkg;

    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = 7;

    typedef enum logic [3:0] {
        OP_INS_HEAD = 4'd0,
        OP_INS_TAIL = 4'd1,
        OP_INS_POS  = 4'd2,
        OP_REM_HEAD = 4'd3,
        OP_REM_TAIL = 4'd4,
        OP_REM_POS  = 4'd5,
        OP_LIST_FWD = 4'd6,
        OP_LIST_BCK = 4'd7,
        OP_CLEAR    = 4'd8
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST,
        S_OUT
    } state_t;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               has_previous;
        logic               has_next;
        logic [1:0]         status;
        logic [CW-1:0]      length;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] new_value;
        logic [7:0]         position;
    } request_t;

endpackage

FILE: rtl/pol_if.sv
interface pol_req_if;
    import pol_pkg::*;
    logic     valid;
    logic     ready;
    request_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pol_res_if;
    import pol_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pol_ram.sv
module pol_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/positional_ordered_list.sv
// Positional ordered list of up to 64 signed 32-bit values held in one RAM.
// Channels: req carries operation, new_value and position; res returns
// result items with item_value, neighbour flags, status, length and last.
// An edit operation gives one result item. An insert or remove moves every
// element between the edit point and the tail by one cell; each element is
// read in S_SHIFT_RD, then written back one cell on in S_SHIFT_WR through the
// RAM write port. Head-side edits of a long list are the slowest case.
// Listing gives one result item per element, one element each cycle when
// the receiver takes them, once the first RAM read has been issued;
// an empty listing gives one item with status empty.
// A new item is taken only once all results of the previous one are taken.
// When the receiver stalls the result register holds its item and the walk
// pauses. Reset empties the list at once; RAM contents need no clearing.
module positional_ordered_list (
    input logic clk,
    input logic rst_n,
    pol_req_if.sink   req,
    pol_res_if.source res
);
    import pol_pkg::*;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [3:0]         op_reg, op_next;
    logic signed [31:0] val_reg, val_next;
    logic [CW-1:0]      idx_reg, idx_next;   // cell being moved or listed
    logic [CW-1:0]      stop_reg, stop_next; // edit point
    logic [CW-1:0]      seen_reg, seen_next; // listed so far
    logic               rd_pend_reg, rd_pend_next;
    result_t            res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [31:0]        wdata, rdata;

    pol_ram #(.DEPTH(CAPACITY), .WIDTH(32)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign req.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        stop_reg <= stop_next;
        seen_reg <= seen_next;
        res_reg  <= res_next;
    end

    // Sequencer: decodes an item, walks the RAM and forms the results.
    always_comb
    begin
        logic [CW-1:0] p0;
        logic          take;
        logic          free;
        logic [CW-1:0] li;
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        stop_next      = stop_reg;
        seen_next      = seen_reg;
        rd_pend_next   = 1'b0;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        we             = 1'b0;
        waddr          = idx_reg[AW-1:0];
        wdata          = rdata;
        raddr          = idx_reg[AW-1:0];
        p0 = (req.data.position <= 8'd1) ? '0 : CW'(req.data.position - 8'd1);
        take = req.valid && req.ready;
        free = !res_valid_reg || res.ready;
        li   = '0;
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    op_next  = req.data.operation;
                    val_next = req.data.new_value;
                    res_next = '0;
                    res_next.last   = 1'b1;
                    res_next.length = count_reg;
                    case (req.data.operation)
                        OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                if (req.data.operation == OP_INS_HEAD)
                                    stop_next = '0;
                                else if (req.data.operation == OP_INS_TAIL)
                                    stop_next = count_reg;
                                else
                                    stop_next = (p0 > count_reg || req.data.position > 8'd64)
                                        ? count_reg : p0;
                                idx_next   = count_reg;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS:
                        begin
                            if (req.data.operation == OP_REM_HEAD)
                                stop_next = '0;
                            else if (req.data.operation == OP_REM_TAIL)
                                stop_next = count_reg - CW'(1);
                            else
                                stop_next = p0;
                            if (count_reg == '0 || (req.data.operation == OP_REM_POS
                                && (req.data.position > 8'd64 || p0 >= count_reg)))
                            begin
                                res_next.status = ST_EMPTY;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                idx_next   = (req.data.operation == OP_REM_HEAD)
                                    ? '0 : stop_next;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        OP_LIST_FWD, OP_LIST_BCK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                idx_next   = (req.data.operation == OP_LIST_FWD)
                                    ? '0 : count_reg - CW'(1);
                                seen_next  = '0;
                                state_next = S_LIST;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            res_next.length = '0;
                            res_valid_next  = 1'b1;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // Insert moves cells up from the tail; remove moves them down.
            S_SHIFT_RD:
            begin
                if (op_reg <= 4'(OP_INS_POS))
                begin
                    if (idx_reg == stop_reg)
                    begin
                        we         = 1'b1;
                        wdata      = val_reg;
                        count_next = count_reg + CW'(1);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        raddr      = AW'(idx_reg - CW'(1));
                        state_next = S_SHIFT_WR;
                    end
                end
                else
                begin
                    if (idx_reg + CW'(1) >= count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        raddr      = AW'(idx_reg + CW'(1));
                        state_next = S_SHIFT_WR;
                    end
                end
            end

            S_SHIFT_WR:
            begin
                we    = 1'b1;
                wdata = rdata;
                if (op_reg <= 4'(OP_INS_POS))
                    idx_next = idx_reg - CW'(1);
                else
                    idx_next = idx_reg + CW'(1);
                state_next = S_SHIFT_RD;
            end

            S_OUT:
            begin
                res_next = '0;
                res_next.last   = 1'b1;
                res_next.length = count_reg;
                res_valid_next  = 1'b1;
                state_next      = S_IDLE;
            end

            // A read is issued; its data comes back through the RAM read register and
            // moves into the result register once that register is free.
            S_LIST:
            begin
                if (rd_pend_reg && free)
                begin
                    li = (op_reg == 4'(OP_LIST_FWD)) ? seen_reg
                        : count_reg - CW'(1) - seen_reg;
                    res_next.item_value   = rdata;
                    res_next.has_previous = (li != '0);
                    res_next.has_next     = (li + CW'(1) < count_reg);
                    res_next.status       = ST_OK;
                    res_next.length       = count_reg;
                    res_next.last         = (seen_reg + CW'(1) == count_reg);
                    res_valid_next        = 1'b1;
                    seen_next             = seen_reg + CW'(1);
                    if (seen_reg + CW'(1) == count_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next = (op_reg == 4'(OP_LIST_FWD))
                            ? idx_reg + CW'(1) : idx_reg - CW'(1);
                        raddr        = AW'(idx_next);
                        rd_pend_next = 1'b1;
                    end
                end
                else if (rd_pend_reg)
                begin
                    raddr        = idx_reg[AW-1:0];
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    raddr        = idx_reg[AW-1:0];
                    rd_pend_next = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/pol_checker.sv
module pol_props (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   res_valid,
    input logic                   res_ready,
    input pol_pkg::result_t       res_data
);
    import pol_pkg::*;

    // A stalled result item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // Length never exceeds capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.length <= CW'(CAPACITY))
        else $error("length beyond capacity");

    // No new item while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req_ready)
        else $error("item taken with a result pending");

    // A refused insert only happens on a full list.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status == ST_FULL |-> res_data.length == CW'(CAPACITY))
        else $error("full status on a list that is not full");
endmodule

bind positional_ordered_list pol_props u_pol_props (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
